@@ hdl/assert_macros.svh @@
// Assertion helpers for the permutation mutation engine.
// They expect a clock named clk_i and an active-low reset named rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pme_pkg.sv @@
`default_nettype none
package pme_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned LEN_BITS    = 32;
  localparam int unsigned ADDR_BITS   = $clog2(MAX_ENTRIES);
  localparam int unsigned POS_BITS    = ADDR_BITS + 1;
  localparam int unsigned ENTRY_BITS  = ID_BITS + LEN_BITS;
  localparam int unsigned ALEN_BITS   = 11;
  localparam int unsigned THR_BITS    = 17;
  localparam int unsigned DRAW_BITS   = 16;
  localparam int unsigned CFG_BITS    = 17;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned NSPANS      = 3;
  localparam int unsigned SPAN_IDX_BITS = 2;

  localparam logic [1:0] OPC_WRITE  = 2'd0;
  localparam logic [1:0] OPC_READ   = 2'd1;
  localparam logic [1:0] OPC_MUTATE = 2'd2;

  localparam logic [2:0] MOP_SWAP   = 3'd0;
  localparam logic [2:0] MOP_ROTATE = 3'd1;
  localparam logic [2:0] MOP_INSERT = 3'd2;
  localparam logic [2:0] MOP_INVERT = 3'd3;
  localparam logic [2:0] MOP_NONE   = 3'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_SWAP   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_ROTATE = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_INSERT = 2'd3;

  localparam logic [ALEN_BITS-1:0] ACTIVE_LENGTH_RST = 11'd1024;
  localparam logic [THR_BITS-1:0]  THRESH_SWAP_RST   = 17'd13107;
  localparam logic [THR_BITS-1:0]  THRESH_ROTATE_RST = 17'd26214;
  localparam logic [THR_BITS-1:0]  THRESH_INSERT_RST = 17'd45875;

  typedef logic [POS_BITS-1:0] pos_t;

endpackage
`default_nettype wire

@@ hdl/permutation_mutation_engine_top.sv @@
// Permutation mutation engine: keeps one ordering of up to 1024 entries (contig id and
// length) in a single-port-read, single-port-write synchronous RAM.
// Requests arrive on in_valid_i / in_stall_o with opcode write, read or mutate; every
// request gives exactly one result on out_valid_o / out_stall_i.
// A write result appears in the cycle after acceptance; a read result passes the RAM read
// register and ST_RDWAIT first. A mutate request runs a small sequencer that reverses up to
// three spans of the RAM. Each exchange of two entries is two reads (ST_LOOP, ST_RDHI) and
// two writes (ST_WRLO, ST_WRHI). A swap is a single exchange; inversion reverses one span,
// insertion two and rotation three spans of the active length L (none when pos_a is zero).
// Rejected mutations (pos_a, or pos_b unless rotating, >= active length) answer like writes.
// One request is in flight at a time; the input stalls while the sequencer runs.
// The output register lets a new request enter while the last result is being taken.
// If the receiver stalls, the result is held unchanged and new requests wait.
// Reset clears the control state and loads the register defaults; RAM contents are
// undefined until written and no clearing pass runs.
// Configuration writes are taken on any cycle and must be issued only while idle.
`default_nettype none
`include "assert_macros.svh"
module permutation_mutation_engine_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pme_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [pme_pkg::CFG_BITS-1:0]      cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        opcode_i,
  input  wire logic [pme_pkg::ADDR_BITS-1:0]     entry_addr_i,
  input  wire logic [pme_pkg::ID_BITS-1:0]       entry_id_i,
  input  wire logic [pme_pkg::LEN_BITS-1:0]      entry_len_i,
  input  wire logic [pme_pkg::DRAW_BITS-1:0]     op_draw_i,
  input  wire logic [pme_pkg::ADDR_BITS-1:0]     pos_a_i,
  input  wire logic [pme_pkg::ADDR_BITS-1:0]     pos_b_i,
  input  wire logic                              dir_draw_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [pme_pkg::ID_BITS-1:0]            rd_id_o,
  output logic [pme_pkg::LEN_BITS-1:0]           rd_len_o,
  output logic [2:0]                             applied_op_o,
  output logic                                   status_o
);
  import pme_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RDWAIT = 3'd1;
  localparam logic [2:0] ST_SPAN   = 3'd2;
  localparam logic [2:0] ST_LOOP   = 3'd3;
  localparam logic [2:0] ST_RDHI   = 3'd4;
  localparam logic [2:0] ST_WRLO   = 3'd5;
  localparam logic [2:0] ST_WRHI   = 3'd6;

  logic [ENTRY_BITS-1:0] mem [MAX_ENTRIES];
  logic [ENTRY_BITS-1:0] rdata_q;
  logic                  mem_re;
  logic [ADDR_BITS-1:0]  mem_raddr;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [ENTRY_BITS-1:0] mem_wdata;

  logic [ALEN_BITS-1:0] active_len_q;
  logic [THR_BITS-1:0]  thr_swap_q;
  logic [THR_BITS-1:0]  thr_rot_q;
  logic [THR_BITS-1:0]  thr_ins_q;

  logic [2:0]              state_q, state_d;
  pos_t                    lo_q, lo_d;
  pos_t                    hi_q, hi_d;
  logic [SPAN_IDX_BITS-1:0] idx_q, idx_d;
  logic [SPAN_IDX_BITS-1:0] nsp_q;
  logic                    single_q;
  logic [2:0]              mop_q;
  logic [ENTRY_BITS-1:0]   tmp_q;
  pos_t                    span_lo_q [NSPANS];
  pos_t                    span_hi_q [NSPANS];

  logic                    in_acc;
  logic                    span_ld;
  pos_t                    span_lo_c [NSPANS];
  pos_t                    span_hi_c [NSPANS];
  logic [SPAN_IDX_BITS-1:0] nsp_c;
  logic                    single_c;
  logic [2:0]              sel_c;
  logic                    pos_err;
  logic [ALEN_BITS-1:0]    len_sat;
  pos_t                    pa_x, pb_x, p_x, q_x;
  logic [THR_BITS-1:0]     draw_x;

  logic                    out_valid_q;
  logic [ID_BITS-1:0]      rd_id_q;
  logic [LEN_BITS-1:0]     rd_len_q;
  logic [2:0]              op_q;
  logic                    status_q;
  logic                    ld;
  logic [ID_BITS-1:0]      ld_id;
  logic [LEN_BITS-1:0]     ld_len;
  logic [2:0]              ld_op;
  logic                    ld_st;

  assign in_stall_o   = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign rd_id_o      = rd_id_q;
  assign rd_len_o     = rd_len_q;
  assign applied_op_o = op_q;
  assign status_o     = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_len_q <= ACTIVE_LENGTH_RST;
      thr_swap_q   <= THRESH_SWAP_RST;
      thr_rot_q    <= THRESH_ROTATE_RST;
      thr_ins_q    <= THRESH_INSERT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACTIVE_LENGTH: active_len_q <= cfg_wdata_i[ALEN_BITS-1:0];
        REG_THRESH_SWAP:   thr_swap_q   <= cfg_wdata_i[THR_BITS-1:0];
        REG_THRESH_ROTATE: thr_rot_q    <= cfg_wdata_i[THR_BITS-1:0];
        REG_THRESH_INSERT: thr_ins_q    <= cfg_wdata_i[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_sat = (active_len_q > ALEN_BITS'(MAX_ENTRIES)) ? ALEN_BITS'(MAX_ENTRIES)
                                                       : active_len_q;
    pa_x    = {1'b0, pos_a_i};
    pb_x    = {1'b0, pos_b_i};
    p_x     = (pa_x < pb_x) ? pa_x : pb_x;
    q_x     = (pa_x < pb_x) ? pb_x : pa_x;
    draw_x  = {1'b0, op_draw_i};
    if (draw_x < thr_swap_q) begin
      sel_c = MOP_SWAP;
    end else if (draw_x < thr_rot_q) begin
      sel_c = MOP_ROTATE;
    end else if (draw_x < thr_ins_q) begin
      sel_c = MOP_INSERT;
    end else begin
      sel_c = MOP_INVERT;
    end
    pos_err = (pa_x >= POS_BITS'(len_sat)) ||
              ((sel_c != MOP_ROTATE) && (pb_x >= POS_BITS'(len_sat)));

    for (int i = 0; i < NSPANS; i++) begin
      span_lo_c[i] = p_x;
      span_hi_c[i] = q_x;
    end
    single_c = 1'b0;
    nsp_c    = 2'd1;
    unique case (sel_c)
      MOP_SWAP: begin
        single_c = 1'b1;
      end
      MOP_ROTATE: begin
        span_lo_c[0] = '0;
        span_hi_c[0] = pa_x - POS_BITS'(1);
        span_lo_c[1] = pa_x;
        span_hi_c[1] = POS_BITS'(len_sat) - POS_BITS'(1);
        span_lo_c[2] = '0;
        span_hi_c[2] = POS_BITS'(len_sat) - POS_BITS'(1);
        nsp_c = (pa_x == '0) ? 2'd0 : 2'd3;
      end
      MOP_INSERT: begin
        nsp_c = 2'd2;
        if (dir_draw_i) begin
          span_lo_c[0] = p_x + POS_BITS'(1);
        end else begin
          span_lo_c[1] = p_x + POS_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    idx_d     = idx_q;
    span_ld   = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = lo_q[ADDR_BITS-1:0];
    mem_we    = 1'b0;
    mem_waddr = lo_q[ADDR_BITS-1:0];
    mem_wdata = rdata_q;
    ld        = 1'b0;
    ld_id     = '0;
    ld_len    = '0;
    ld_op     = MOP_NONE;
    ld_st     = STATUS_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_i)
            OPC_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = entry_addr_i;
              mem_wdata = {entry_id_i, entry_len_i};
              ld        = 1'b1;
            end
            OPC_READ: begin
              mem_re    = 1'b1;
              mem_raddr = entry_addr_i;
              state_d   = ST_RDWAIT;
            end
            OPC_MUTATE: begin
              if (pos_err) begin
                ld    = 1'b1;
                ld_st = STATUS_ERR;
              end else begin
                span_ld = 1'b1;
                idx_d   = '0;
                state_d = ST_SPAN;
              end
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        ld      = 1'b1;
        ld_id   = rdata_q[ENTRY_BITS-1:LEN_BITS];
        ld_len  = rdata_q[LEN_BITS-1:0];
        state_d = ST_IDLE;
      end
      ST_SPAN: begin
        if (idx_q == nsp_q) begin
          ld      = 1'b1;
          ld_op   = mop_q;
          state_d = ST_IDLE;
        end else begin
          lo_d    = span_lo_q[idx_q];
          hi_d    = span_hi_q[idx_q];
          idx_d   = idx_q + SPAN_IDX_BITS'(1);
          state_d = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (lo_q < hi_q) begin
          mem_re    = 1'b1;
          mem_raddr = lo_q[ADDR_BITS-1:0];
          state_d   = ST_RDHI;
        end else begin
          state_d = ST_SPAN;
        end
      end
      ST_RDHI: begin
        mem_re    = 1'b1;
        mem_raddr = hi_q[ADDR_BITS-1:0];
        state_d   = ST_WRLO;
      end
      ST_WRLO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q[ADDR_BITS-1:0];
        mem_wdata = rdata_q;
        state_d   = ST_WRHI;
      end
      ST_WRHI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_q[ADDR_BITS-1:0];
        mem_wdata = tmp_q;
        lo_d      = lo_q + POS_BITS'(1);
        hi_d      = hi_q - POS_BITS'(1);
        state_d   = single_q ? ST_SPAN : ST_LOOP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (state_q == ST_RDHI) begin
      tmp_q <= rdata_q;
    end
    if (span_ld) begin
      nsp_q    <= nsp_c;
      single_q <= single_c;
      mop_q    <= sel_c;
      for (int i = 0; i < NSPANS; i++) begin
        span_lo_q[i] <= span_lo_c[i];
        span_hi_q[i] <= span_hi_c[i];
      end
    end
    if (ld) begin
      rd_id_q  <= ld_id;
      rd_len_q <= ld_len;
      op_q     <= ld_op;
      status_q <= ld_st;
    end
  end

  `PME_ASSERT_NOW(a_accept_idle, in_valid_i && !in_stall_o, state_q == ST_IDLE, "request accepted while the sequencer is busy")
  `PME_ASSERT_NOW(a_busy_no_result, state_q != ST_IDLE, !out_valid_q, "result pending while the sequencer is busy")
  `PME_ASSERT_NOW(a_exchange_order, state_q == ST_WRHI, lo_q < hi_q, "exchange issued with unordered positions")
  `PME_ASSERT_NEXT(a_read_then_write, state_q == ST_RDHI, state_q == ST_WRLO, "exchange read not followed by its write")

endmodule
`default_nettype wire

@@ tb/sv/pme_order_checker.sv @@
`timescale 1ns / 1ps
module pme_order_checker
  import pme_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [1:0]              opcode_i,
  input  logic [ADDR_BITS-1:0]    entry_addr_i,
  input  logic [ID_BITS-1:0]      entry_id_i,
  input  logic [LEN_BITS-1:0]     entry_len_i,
  input  logic [DRAW_BITS-1:0]    op_draw_i,
  input  logic [ADDR_BITS-1:0]    pos_a_i,
  input  logic [ADDR_BITS-1:0]    pos_b_i,
  input  logic                    dir_draw_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [ID_BITS-1:0]      rd_id_i,
  input  logic [LEN_BITS-1:0]     rd_len_i,
  input  logic [2:0]              applied_op_i,
  input  logic                    status_i,
  output int unsigned             mismatches_o,
  output int unsigned             outstanding_o
);

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [LEN_BITS-1:0] len;
  } entry_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  rd_id;
    logic [LEN_BITS-1:0] rd_len;
    logic [2:0]          op;
    logic                status;
  } outcome_t;

  entry_t               order_copy [MAX_ENTRIES];
  logic [ALEN_BITS-1:0] active_len;
  logic [THR_BITS-1:0]  thr_swap;
  logic [THR_BITS-1:0]  thr_rotate;
  logic [THR_BITS-1:0]  thr_insert;
  outcome_t             awaited_outcomes [$];
  int unsigned          mismatch_count = 0;

  task automatic apply_request(input logic [1:0] opc, input logic [ADDR_BITS-1:0] addr,
                               input logic [ID_BITS-1:0] id, input logic [LEN_BITS-1:0] len,
                               input logic [DRAW_BITS-1:0] draw,
                               input logic [ADDR_BITS-1:0] pa, input logic [ADDR_BITS-1:0] pb,
                               input logic dir, output outcome_t res);
    entry_t      snapshot [MAX_ENTRIES];
    int unsigned span;
    int unsigned lo;
    int unsigned hi;
    int unsigned i;
    logic [2:0]  pick;
    res = '0;
    res.op = MOP_NONE;
    res.status = STATUS_OK;
    case (opc)
      OPC_WRITE: begin
        order_copy[addr] = '{id: id, len: len};
      end
      OPC_READ: begin
        res.rd_id = order_copy[addr].id;
        res.rd_len = order_copy[addr].len;
      end
      OPC_MUTATE: begin
        span = (active_len > MAX_ENTRIES) ? MAX_ENTRIES : active_len;
        if (draw < thr_swap) begin
          pick = MOP_SWAP;
        end else if (draw < thr_rotate) begin
          pick = MOP_ROTATE;
        end else if (draw < thr_insert) begin
          pick = MOP_INSERT;
        end else begin
          pick = MOP_INVERT;
        end
        if (pa >= span || (pick != MOP_ROTATE && pb >= span)) begin
          res.status = STATUS_ERR;
        end else begin
          res.op = pick;
          lo = (pa < pb) ? pa : pb;
          hi = (pa < pb) ? pb : pa;
          snapshot = order_copy;
          case (pick)
            MOP_SWAP: begin
              order_copy[lo] = snapshot[hi];
              order_copy[hi] = snapshot[lo];
            end
            MOP_ROTATE: begin
              for (i = 0; i < span; i++) order_copy[i] = snapshot[(i + pa) % span];
            end
            MOP_INSERT: begin
              if (!dir) begin
                order_copy[lo] = snapshot[hi];
                for (i = lo + 1; i <= hi; i++) order_copy[i] = snapshot[i - 1];
              end else begin
                order_copy[hi] = snapshot[lo];
                for (i = lo; i < hi; i++) order_copy[i] = snapshot[i + 1];
              end
            end
            default: begin
              for (i = lo; i <= hi; i++) order_copy[i] = snapshot[lo + hi - i];
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      active_len = ACTIVE_LENGTH_RST;
      thr_swap = THRESH_SWAP_RST;
      thr_rotate = THRESH_ROTATE_RST;
      thr_insert = THRESH_INSERT_RST;
      awaited_outcomes.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{rd_id: rd_id_i, rd_len: rd_len_i, op: applied_op_i, status: status_i};
        if (awaited_outcomes.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result at %0t: id %h len %h op %0d status %0d",
                     $realtime, got.rd_id, got.rd_len, got.op, got.status);
          mismatch_count++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.rd_id !== want.rd_id || got.rd_len !== want.rd_len ||
              got.op !== want.op || got.status !== want.status) begin
            if (mismatch_count < 10)
              $display({"result mismatch at %0t: expected id %h len %h op %0d status %0d,",
                        " got id %h len %h op %0d status %0d"}, $realtime,
                       want.rd_id, want.rd_len, want.op, want.status,
                       got.rd_id, got.rd_len, got.op, got.status);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_request(opcode_i, entry_addr_i, entry_id_i, entry_len_i, op_draw_i,
                      pos_a_i, pos_b_i, dir_draw_i, want);
        awaited_outcomes.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ACTIVE_LENGTH: active_len = cfg_wdata_i[ALEN_BITS-1:0];
          REG_THRESH_SWAP:   thr_swap = cfg_wdata_i[THR_BITS-1:0];
          REG_THRESH_ROTATE: thr_rotate = cfg_wdata_i[THR_BITS-1:0];
          default:           thr_insert = cfg_wdata_i[THR_BITS-1:0];
        endcase
      end
    end
    mismatches_o <= mismatch_count;
    outstanding_o <= awaited_outcomes.size();
  end

endmodule

@@ tb/sv/permutation_mutation_engine_top_tb.sv @@
`timescale 1ns / 1ps
module permutation_mutation_engine_top_tb;
  import pme_pkg::*;

  localparam logic [1:0] OPC_UNUSED  = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [CFG_BITS-1:0]     cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              opcode_i = OPC_WRITE;
  logic [ADDR_BITS-1:0]    entry_addr_i = '0;
  logic [ID_BITS-1:0]      entry_id_i = '0;
  logic [LEN_BITS-1:0]     entry_len_i = '0;
  logic [DRAW_BITS-1:0]    op_draw_i = '0;
  logic [ADDR_BITS-1:0]    pos_a_i = '0;
  logic [ADDR_BITS-1:0]    pos_b_i = '0;
  logic                    dir_draw_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [ID_BITS-1:0]      rd_id_o;
  logic [LEN_BITS-1:0]     rd_len_o;
  logic [2:0]              applied_op_o;
  logic                    status_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  bit          send_jitter = 1'b1;
  bit          stall_jitter = 1'b1;
  int unsigned hold_tokens = 0;
  int unsigned holds_granted = 0;
  int unsigned hold_left = 0;

  permutation_mutation_engine_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .entry_addr_i (entry_addr_i),
    .entry_id_i   (entry_id_i),
    .entry_len_i  (entry_len_i),
    .op_draw_i    (op_draw_i),
    .pos_a_i      (pos_a_i),
    .pos_b_i      (pos_b_i),
    .dir_draw_i   (dir_draw_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rd_id_o      (rd_id_o),
    .rd_len_o     (rd_len_o),
    .applied_op_o (applied_op_o),
    .status_o     (status_o)
  );

  pme_order_checker order_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .opcode_i      (opcode_i),
    .entry_addr_i  (entry_addr_i),
    .entry_id_i    (entry_id_i),
    .entry_len_i   (entry_len_i),
    .op_draw_i     (op_draw_i),
    .pos_a_i       (pos_a_i),
    .pos_b_i       (pos_b_i),
    .dir_draw_i    (dir_draw_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rd_id_i       (rd_id_o),
    .rd_len_i      (rd_len_o),
    .applied_op_i  (applied_op_o),
    .status_i      (status_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // A long hold-off keeps the result side blocked so that requests back up.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (holds_granted != hold_tokens) begin
      holds_granted++;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= stall_jitter && ($urandom_range(99) < 35);
    end
  end

  task automatic send_request(input logic [1:0] opc, input logic [ADDR_BITS-1:0] addr,
                              input logic [ID_BITS-1:0] id, input logic [LEN_BITS-1:0] len,
                              input logic [DRAW_BITS-1:0] draw,
                              input logic [ADDR_BITS-1:0] pa, input logic [ADDR_BITS-1:0] pb,
                              input logic dir);
    while (send_jitter && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= opc;
    entry_addr_i <= addr;
    entry_id_i <= id;
    entry_len_i <= len;
    op_draw_i <= draw;
    pos_a_i <= pa;
    pos_b_i <= pb;
    dir_draw_i <= dir;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [CFG_BITS-1:0] alen, input logic [CFG_BITS-1:0] ts,
                                input logic [CFG_BITS-1:0] tr, input logic [CFG_BITS-1:0] ti);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_ACTIVE_LENGTH;
    cfg_wdata_i <= alen;
    @(posedge clk_i);
    cfg_idx_i <= REG_THRESH_SWAP;
    cfg_wdata_i <= ts;
    @(posedge clk_i);
    cfg_idx_i <= REG_THRESH_ROTATE;
    cfg_wdata_i <= tr;
    @(posedge clk_i);
    cfg_idx_i <= REG_THRESH_INSERT;
    cfg_wdata_i <= ti;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_BITS-1:0] alen, input logic [CFG_BITS-1:0] ts,
                           input logic [CFG_BITS-1:0] tr, input logic [CFG_BITS-1:0] ti,
                           input int unsigned count, input bit jitter, input bit squeeze);
    int unsigned          span;
    int unsigned          roll;
    logic [1:0]           opc;
    logic [ADDR_BITS-1:0] addr;
    logic [ID_BITS-1:0]   id;
    logic [LEN_BITS-1:0]  len;
    logic [DRAW_BITS-1:0] draw;
    logic [ADDR_BITS-1:0] pa;
    logic [ADDR_BITS-1:0] pb;
    logic                 dir;
    apply_settings(alen, ts, tr, ti);
    span = (alen[ALEN_BITS-1:0] > MAX_ENTRIES) ? MAX_ENTRIES : alen[ALEN_BITS-1:0];
    send_jitter = jitter;
    stall_jitter <= jitter;
    if (squeeze) hold_tokens <= hold_tokens + 1;
    repeat (count) begin
      roll = $urandom_range(99);
      addr = $urandom_range(MAX_ENTRIES - 1);
      id = $urandom;
      len = $urandom;
      draw = $urandom;
      pa = $urandom_range(MAX_ENTRIES - 1);
      pb = $urandom_range(MAX_ENTRIES - 1);
      dir = $urandom_range(1);
      if (roll < 45) begin
        opc = OPC_MUTATE;
        if (span != 0) begin
          pa = $urandom_range(span - 1);
          pb = $urandom_range(span - 1);
        end
        if (span < MAX_ENTRIES && $urandom_range(9) == 0) begin
          if ($urandom_range(1)) pa = $urandom_range(MAX_ENTRIES - 1, span);
          else pb = $urandom_range(MAX_ENTRIES - 1, span);
        end
      end else if (roll < 65) begin
        opc = OPC_WRITE;
      end else if (roll < 90) begin
        opc = OPC_READ;
      end else if (roll < 95) begin
        opc = OPC_UNUSED;
      end else begin
        opc = OPC_MUTATE;
      end
      send_request(opc, addr, id, len, draw, pa, pb, dir);
    end
    drain_block();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every entry so that no later request touches an unwritten one.
    for (int a = 0; a < MAX_ENTRIES; a++)
      send_request(OPC_WRITE, a[ADDR_BITS-1:0], $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);

    send_request(OPC_WRITE, 10'd0, 16'h0000, 32'h0000_0000, 16'd0, 10'd0, 10'd0, 1'b0);
    send_request(OPC_WRITE, 10'd1023, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 10'd1023, 10'd1023,
                 1'b1);
    send_request(OPC_READ, 10'd0, 16'd0, 32'd0, 16'd0, 10'd0, 10'd0, 1'b0);
    send_request(OPC_READ, 10'd1023, 16'd0, 32'd0, 16'd0, 10'd0, 10'd0, 1'b0);
    send_request(OPC_UNUSED, 10'd1023, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 10'd1023, 10'd1023,
                 1'b1);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd0, 10'd1023, 10'd0, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd13106, 10'd5, 10'd5, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd13107, 10'd0, 10'd7, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd26213, 10'd1, 10'd0, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd26214, 10'd900, 10'd3, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd45874, 10'd3, 10'd40, 1'b1);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd45875, 10'd10, 10'd2, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'hFFFF, 10'd0, 10'd1023, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd20000, 10'd1023, 10'd0, 1'b0);
    send_request(OPC_READ, 10'd512, 16'd0, 32'd0, 16'd0, 10'd0, 10'd0, 1'b0);
    drain_block();

    apply_settings(17'd10, THRESH_SWAP_RST, THRESH_ROTATE_RST, THRESH_INSERT_RST);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd0, 10'd10, 10'd0, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd0, 10'd0, 10'd10, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd20000, 10'd3, 10'd1023, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd20000, 10'd10, 10'd0, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd30000, 10'd2, 10'd1023, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'hFFFF, 10'd1023, 10'd1023, 1'b0);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd30000, 10'd9, 10'd0, 1'b1);
    send_request(OPC_READ, 10'd9, 16'd0, 32'd0, 16'd0, 10'd0, 10'd0, 1'b0);
    drain_block();

    apply_settings(17'd0, THRESH_SWAP_RST, THRESH_ROTATE_RST, THRESH_INSERT_RST);
    send_request(OPC_MUTATE, 10'd0, 16'd0, 32'd0, 16'd0, 10'd0, 10'd0, 1'b0);
    send_request(OPC_UNUSED, 10'd0, 16'd0, 32'd0, 16'd0, 10'd0, 10'd0, 1'b0);
    drain_block();

    run_phase(17'd37, 17'd16384, 17'd32768, 17'd49152, 120, 1'b0, 1'b0);
    run_phase(17'd1, 17'd0, 17'd0, 17'd0, 30, 1'b1, 1'b0);
    run_phase(17'd16, 17'd65536, 17'd65536, 17'd65536, 40, 1'b1, 1'b0);
    run_phase(17'h1FFFF, THRESH_SWAP_RST, THRESH_ROTATE_RST, THRESH_INSERT_RST, 16, 1'b1, 1'b0);
    run_phase(17'd1024, 17'd0, 17'd65536, 17'd65536, 8, 1'b1, 1'b0);
    run_phase(17'd5, 17'd0, 17'd0, 17'd65536, 40, 1'b1, 1'b0);
    run_phase(17'd64, THRESH_SWAP_RST, THRESH_ROTATE_RST, THRESH_INSERT_RST, 150, 1'b1, 1'b1);
    run_phase(17'd200, $urandom_range(65536), $urandom_range(65536), $urandom_range(65536), 80,
              1'b1, 1'b1);
    run_phase(17'd2, 17'd30000, 17'd30000, 17'd60000, 40, 1'b1, 1'b0);
    run_phase(17'd0, 17'd65535, 17'd65535, 17'd65535, 20, 1'b1, 1'b0);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/pme_pkg.sv
hdl/permutation_mutation_engine_top.sv
tb/sv/pme_order_checker.sv
tb/sv/permutation_mutation_engine_top_tb.sv
